// ===== hw/rtl/gly_pkg.sv =====
package gly_pkg;

   // Parity part P of the parity-check matrix H = [I | P], row 0 first.
   localparam logic [11:0] PAR_ROWS [12] = '{
      12'h8ed, 12'h1db, 12'h3b5, 12'h769, 12'hed1, 12'hda3,
      12'hb47, 12'h68f, 12'hd1d, 12'ha3b, 12'h477, 12'hffe
   };

   // Outcome of a search of the twelve parity rows.
   typedef struct packed {
      logic       hit;
      logic [3:0] idx;
   } gly_search_type;

   // Number of set bits in a 12-bit word.
   function automatic logic [3:0] ones_count(input logic [11:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 12; i++) begin
         n = n + {3'b000, v[i]};
      end
      return n;
   endfunction

endpackage

// ===== hw/rtl/gly_row_search.sv =====
module gly_row_search
   import gly_pkg::*;
(
   input  logic [11:0]    vec,
   output gly_search_type result
);

   // Every row is tested at once; the lowest matching row wins.
   always_comb begin
      result.hit = 1'b0;
      result.idx = '0;
      for (int i = 11; i >= 0; i--) begin
         if (ones_count(vec ^ PAR_ROWS[i]) <= 4'd2) begin
            result.hit = 1'b1;
            result.idx = 4'(i);
         end
      end
   end

endmodule

// ===== hw/rtl/golay_24_12_codeword_decoder_top.sv =====
// Extended Golay (24,12) decoder: one received 24-bit word per beat, parity in
// bits 23..12 and message in bits 11..0, gives the corrected 12-bit message and
// a flag raised when no error pattern of up to three bits is found, in which
// case the message is the raw low 12 bits. The block takes a new word in every
// cycle while its output is not stalled. It is a three-stage pipeline (syndrome,
// first row search with s*P, second row search with correction), each stage
// registered; a stalled output holds the pipeline without losing beats.
module golay_24_12_codeword_decoder_top
   import gly_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [23:0] req_codeword,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_message,
   output logic        rsp_uncorrectable
);

   logic           s1_valid_ff, s1_valid_in;
   logic [11:0]    s1_syn_ff, s1_syn_in;
   logic [11:0]    s1_msg_ff;

   logic           s2_valid_ff, s2_valid_in;
   logic           s2_le3_ff, s2_le3_in;
   gly_search_type s2_srch_ff, srch1;
   logic [11:0]    s2_sp_ff, s2_sp_in;
   logic [11:0]    s2_msg_ff;

   logic           s3_valid_ff, s3_valid_in;
   logic [11:0]    s3_msg_ff, s3_msg_in;
   logic           s3_bad_ff, s3_bad_in;
   gly_search_type srch2;
   logic [3:0]     sp_weight;

   logic           adv1, adv2, adv3;

   // Each stage moves on when it is empty or the stage after it moves on.
   assign adv3      = !s3_valid_ff || rsp_ready;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_ready = adv1;

   assign s1_valid_in = adv1 ? req_valid   : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Stage one: syndrome bit (11-i) is the parity of the word against row i of H.
   always_comb begin
      for (int i = 0; i < 12; i++) begin
         s1_syn_in[11 - i] = req_codeword[23 - i] ^ (^(req_codeword[11:0] & PAR_ROWS[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_syn_ff <= s1_syn_in;
         s1_msg_ff <= req_codeword[11:0];
      end
   end

   // Stage two: syndrome weight, first row search and the product s*P.
   gly_row_search u_search1 (
      .vec    (s1_syn_ff),
      .result (srch1)
   );

   assign s2_le3_in = ones_count(s1_syn_ff) <= 4'd3;

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         s2_sp_in[11 - i] = ^(PAR_ROWS[i] & s1_syn_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_le3_ff  <= s2_le3_in;
         s2_srch_ff <= srch1;
         s2_sp_ff   <= s2_sp_in;
         s2_msg_ff  <= s1_msg_ff;
      end
   end

   // Stage three: second row search and correction of the message bits.
   gly_row_search u_search2 (
      .vec    (s2_sp_ff),
      .result (srch2)
   );

   assign sp_weight = ones_count(s2_sp_ff);

   always_comb begin
      s3_bad_in = 1'b0;
      s3_msg_in = s2_msg_ff;
      if (s2_le3_ff) begin
         // Errors lie in the parity half only.
         s3_msg_in = s2_msg_ff;
      end else if (s2_srch_ff.hit) begin
         s3_msg_in = s2_msg_ff ^ (12'b1 << (4'd11 - s2_srch_ff.idx));
      end else if (sp_weight == 4'd2 || sp_weight == 4'd3) begin
         s3_msg_in = s2_msg_ff ^ s2_sp_ff;
      end else if (srch2.hit) begin
         s3_msg_in = s2_msg_ff ^ s2_sp_ff ^ PAR_ROWS[srch2.idx];
      end else begin
         s3_bad_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_msg_ff <= s3_msg_in;
         s3_bad_ff <= s3_bad_in;
      end
   end

   assign rsp_valid         = s3_valid_ff;
   assign rsp_message       = s3_msg_ff;
   assign rsp_uncorrectable = s3_bad_ff;

`ifndef NO_ASSERTIONS
   // A full pipeline behind a stalled output takes no new word.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && s3_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("word taken while the pipeline is full and stalled");

   // An accepted word occupies the first stage in the next cycle.
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted word lost from the first stage");

   // A row search result always names one of the twelve rows.
   a_row_index: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_srch_ff.hit) |-> (s2_srch_ff.idx <= 4'd11))
      else $error("row search index out of range");
`endif

endmodule
